// ----- hdl/battery_voltage_to_soc_top_macros.svh -----
// Assertion macros shared by the battery voltage to charge design.
`ifndef BATTERY_VOLTAGE_TO_SOC_TOP_MACROS_SVH
`define BATTERY_VOLTAGE_TO_SOC_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define BVS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bvs assertion failed");

// Next-cycle implication, disabled while reset is low.
`define BVS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bvs assertion failed");

`endif

// ----- hdl/bvs_pkg.sv -----
// Shared types, constants and tables for the battery voltage to charge block.
package bvs_pkg;

    localparam int PACK_W         = 17;
    localparam int CELL_W         = 5;
    localparam int PCNT_W         = 4;
    localparam int TREG_W         = 48;
    localparam int NUM_TREG       = 4;
    localparam int MV_W           = 13;
    localparam int SOC_W          = 11;
    localparam int DS_W           = 12;
    localparam int CHG_W          = 10;
    localparam int SUM_W          = 13;
    localparam int NUM_W          = 24;
    localparam int QUO_W          = 11;
    localparam int RECIP_W        = 19;
    localparam int RECIP_SHIFT    = 18;
    localparam int PROD_W         = PACK_W + RECIP_W;
    localparam int QC_W           = PACK_W + CELL_W;
    localparam int ADDR_W         = 6;
    localparam int DATA_W         = 64;
    localparam int MAX_POINTS_DEF = 8;
    localparam int SOC_FULL       = 1000;

    // Bit positions of one packed breakpoint within a 48-bit table register.
    localparam int PT_HI_LSB  = 24;
    localparam int SOC_LSB    = 13;

    localparam logic [CELL_W-1:0] CELLS_RST = CELL_W'(1);
    localparam logic [PCNT_W-1:0] PCNT_RST  = PCNT_W'(8);
    localparam logic [TREG_W-1:0] TP01_RST  = 48'd123763852906600;
    localparam logic [TREG_W-1:0] TP23_RST  = 48'd82528809783200;
    localparam logic [TREG_W-1:0] TP45_RST  = 48'd27549869674200;
    localparam logic [TREG_W-1:0] TP67_RST  = 48'd58721078800;

    typedef enum logic [2:0] {
        REG_CELLS = 3'd0,
        REG_PCNT  = 3'd1,
        REG_TP01  = 3'd2,
        REG_TP23  = 3'd3,
        REG_TP45  = 3'd4,
        REG_TP67  = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_EMPTY  = 2'd0,
        MODE_FULL   = 2'd1,
        MODE_INTERP = 2'd2
    } t_mode;

    typedef struct packed {
        logic [CELL_W-1:0]                 cells;
        logic [PCNT_W-1:0]                 point_count;
        logic [NUM_TREG-1:0][TREG_W-1:0]   tpts;
    } t_cfg;

    // Per-item control that rides alongside the quotient.
    typedef struct packed {
        t_mode              mode;
        logic [SOC_W-1:0]   s1;
        logic               neg;
        logic [PACK_W-1:0]  v;
    } t_ctl;

    typedef struct packed {
        t_ctl               ctl;
        logic [NUM_W-1:0]   rem;
        logic [MV_W-1:0]    den;
        logic [QUO_W-1:0]   quo;
    } t_qstage;

    // floor(2^18 / c); a zero count divides as one.
    function automatic logic [RECIP_W-1:0] recip(input logic [CELL_W-1:0] c);
        logic [RECIP_W-1:0] r;
        case (c)
            5'd0:    r = 19'd262144;
            5'd1:    r = 19'd262144;
            5'd2:    r = 19'd131072;
            5'd3:    r = 19'd87381;
            5'd4:    r = 19'd65536;
            5'd5:    r = 19'd52428;
            5'd6:    r = 19'd43690;
            5'd7:    r = 19'd37449;
            5'd8:    r = 19'd32768;
            5'd9:    r = 19'd29127;
            5'd10:   r = 19'd26214;
            5'd11:   r = 19'd23831;
            5'd12:   r = 19'd21845;
            5'd13:   r = 19'd20164;
            5'd14:   r = 19'd18724;
            5'd15:   r = 19'd17476;
            5'd16:   r = 19'd16384;
            5'd17:   r = 19'd15420;
            5'd18:   r = 19'd14563;
            5'd19:   r = 19'd13797;
            5'd20:   r = 19'd13107;
            5'd21:   r = 19'd12483;
            5'd22:   r = 19'd11915;
            5'd23:   r = 19'd11397;
            5'd24:   r = 19'd10922;
            5'd25:   r = 19'd10485;
            5'd26:   r = 19'd10082;
            5'd27:   r = 19'd9709;
            5'd28:   r = 19'd9362;
            5'd29:   r = 19'd9039;
            5'd30:   r = 19'd8738;
            5'd31:   r = 19'd8456;
            default: r = 19'd262144;
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/battery_voltage_to_soc_top.sv -----
// Top level: pack voltage to per-cell voltage and state of charge, fully pipelined.
//
// Drive start with a pack voltage on i_pack_millivolts; busy never rises, so a
// beat is taken on every cycle that start is high. Each beat comes back as a
// single-cycle o_valid strobe carrying o_cell_millivolts (pack voltage over the
// cell count, truncated) and o_charge_tenths (0..1000, tenths of a percent). The
// receiver cannot stall, so capture results on the strobe. The pipeline has
// three stages for the cell-count reciprocal divide, two for the segment search
// and slope product, eleven for the one-bit-per-stage segment divider and one
// for the final add, clamp and output register. Program the APB registers only
// while no beat is in flight.
`include "battery_voltage_to_soc_top_macros.svh"
module battery_voltage_to_soc_top #(
    parameter int MAX_POINTS = bvs_pkg::MAX_POINTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [bvs_pkg::PACK_W-1:0]    i_pack_millivolts,
    output logic                          o_valid,
    output logic [bvs_pkg::CHG_W-1:0]     o_charge_tenths,
    output logic [bvs_pkg::PACK_W-1:0]    o_cell_millivolts,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bvs_pkg::ADDR_W-1:0]    paddr,
    input  logic [bvs_pkg::DATA_W-1:0]    pwdata,
    output logic [bvs_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    bvs_pkg::t_cfg               w_cfg;
    logic                        w_accept;

    logic                        w_div_valid;
    logic [bvs_pkg::PACK_W-1:0]  w_div_v;

    logic                        w_seg_valid;
    bvs_pkg::t_ctl               w_seg_ctl;
    logic [bvs_pkg::NUM_W-1:0]   w_seg_num;
    logic [bvs_pkg::MV_W-1:0]    w_seg_den;

    logic                        w_q_valid;
    bvs_pkg::t_ctl               w_q_ctl;
    logic [bvs_pkg::QUO_W-1:0]   w_q_quo;

    logic [bvs_pkg::SUM_W-1:0]   w_sum;
    logic [bvs_pkg::CHG_W-1:0]   w_charge;

    logic                        r_out_valid,  n_out_valid;
    logic [bvs_pkg::CHG_W-1:0]   r_out_charge, n_out_charge;
    logic [bvs_pkg::PACK_W-1:0]  r_out_cell,   n_out_cell;

    // Every stage advances each cycle, so there is never backpressure.
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    bvs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Per-cell voltage: reciprocal multiply, then a single remainder fix-up.
    bvs_celldiv u_celldiv (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_accept),
        .i_pack    (i_pack_millivolts),
        .i_cells   (w_cfg.cells),
        .o_valid   (w_div_valid),
        .o_cell_mv (w_div_v)
    );

    // Pick full, empty or the first bracketing segment; form the slope numerator.
    bvs_seg #(
        .MAX_POINTS (MAX_POINTS)
    ) u_seg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_div_valid),
        .i_v     (w_div_v),
        .i_cfg   (w_cfg),
        .o_valid (w_seg_valid),
        .o_ctl   (w_seg_ctl),
        .o_num   (w_seg_num),
        .o_den   (w_seg_den)
    );

    // Divide magnitudes; the sign is put back at the end so it truncates toward zero.
    bvs_qdiv u_qdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_seg_valid),
        .i_ctl   (w_seg_ctl),
        .i_num   (w_seg_num),
        .i_den   (w_seg_den),
        .o_valid (w_q_valid),
        .o_ctl   (w_q_ctl),
        .o_quo   (w_q_quo)
    );

    // Start charge plus signed step; range fits a 13-bit two's complement sum.
    assign w_sum = w_q_ctl.neg
                 ? bvs_pkg::SUM_W'(w_q_ctl.s1) - bvs_pkg::SUM_W'(w_q_quo)
                 : bvs_pkg::SUM_W'(w_q_ctl.s1) + bvs_pkg::SUM_W'(w_q_quo);

    // Clamp to 0..1000, and override for the saturated ends of the table.
    always_comb begin
        case (w_q_ctl.mode)
            bvs_pkg::MODE_FULL: begin
                w_charge = bvs_pkg::CHG_W'(bvs_pkg::SOC_FULL);
            end
            bvs_pkg::MODE_INTERP: begin
                if (w_sum[bvs_pkg::SUM_W-1]) begin
                    w_charge = '0;
                end else if (w_sum > bvs_pkg::SUM_W'(bvs_pkg::SOC_FULL)) begin
                    w_charge = bvs_pkg::CHG_W'(bvs_pkg::SOC_FULL);
                end else begin
                    w_charge = w_sum[bvs_pkg::CHG_W-1:0];
                end
            end
            default: begin
                w_charge = '0;
            end
        endcase
    end

    always_comb begin
        n_out_valid  = w_q_valid;
        n_out_charge = w_charge;
        n_out_cell   = w_q_ctl.v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Hold result payload; only the strobe needs clearing.
    always_ff @(posedge i_clk) begin
        r_out_charge <= n_out_charge;
        r_out_cell   <= n_out_cell;
    end

    assign o_valid           = r_out_valid;
    assign o_charge_tenths   = r_out_charge;
    assign o_cell_millivolts = r_out_cell;

    `BVS_ASSERT_IMPL(a_charge_range, i_clk, i_rst_n, o_valid, o_charge_tenths <= bvs_pkg::CHG_W'(bvs_pkg::SOC_FULL))
    `BVS_ASSERT_IMPL(a_top_full, i_clk, i_rst_n, o_valid && (o_cell_millivolts >= bvs_pkg::PACK_W'(w_cfg.tpts[0][bvs_pkg::MV_W-1:0])), o_charge_tenths == bvs_pkg::CHG_W'(bvs_pkg::SOC_FULL))

endmodule

// ----- hdl/bvs_cfg.sv -----
// APB register file: cell count, point count and breakpoint table.
module bvs_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bvs_pkg::ADDR_W-1:0]    paddr,
    input  logic [bvs_pkg::DATA_W-1:0]    pwdata,
    output logic [bvs_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output bvs_pkg::t_cfg                 o_cfg
);

    bvs_pkg::t_cfg    r_cfg;
    bvs_pkg::t_cfg    n_cfg;
    logic             w_wr;
    bvs_pkg::t_reg_idx w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = bvs_pkg::t_reg_idx'(paddr[bvs_pkg::ADDR_W-1:3]);

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                bvs_pkg::REG_CELLS: n_cfg.cells       = pwdata[bvs_pkg::CELL_W-1:0];
                bvs_pkg::REG_PCNT:  n_cfg.point_count = pwdata[bvs_pkg::PCNT_W-1:0];
                bvs_pkg::REG_TP01:  n_cfg.tpts[0]     = pwdata[bvs_pkg::TREG_W-1:0];
                bvs_pkg::REG_TP23:  n_cfg.tpts[1]     = pwdata[bvs_pkg::TREG_W-1:0];
                bvs_pkg::REG_TP45:  n_cfg.tpts[2]     = pwdata[bvs_pkg::TREG_W-1:0];
                bvs_pkg::REG_TP67:  n_cfg.tpts[3]     = pwdata[bvs_pkg::TREG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cells       <= bvs_pkg::CELLS_RST;
            r_cfg.point_count <= bvs_pkg::PCNT_RST;
            r_cfg.tpts[0]     <= bvs_pkg::TP01_RST;
            r_cfg.tpts[1]     <= bvs_pkg::TP23_RST;
            r_cfg.tpts[2]     <= bvs_pkg::TP45_RST;
            r_cfg.tpts[3]     <= bvs_pkg::TP67_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (w_idx)
            bvs_pkg::REG_CELLS: prdata = bvs_pkg::DATA_W'(r_cfg.cells);
            bvs_pkg::REG_PCNT:  prdata = bvs_pkg::DATA_W'(r_cfg.point_count);
            bvs_pkg::REG_TP01:  prdata = bvs_pkg::DATA_W'(r_cfg.tpts[0]);
            bvs_pkg::REG_TP23:  prdata = bvs_pkg::DATA_W'(r_cfg.tpts[1]);
            bvs_pkg::REG_TP45:  prdata = bvs_pkg::DATA_W'(r_cfg.tpts[2]);
            bvs_pkg::REG_TP67:  prdata = bvs_pkg::DATA_W'(r_cfg.tpts[3]);
            default:            prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hdl/bvs_celldiv.sv -----
// Three-stage pack voltage divider by cell count: reciprocal multiply and fix-up.
`include "battery_voltage_to_soc_top_macros.svh"
module bvs_celldiv (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [bvs_pkg::PACK_W-1:0]    i_pack,
    input  logic [bvs_pkg::CELL_W-1:0]    i_cells,
    output logic                          o_valid,
    output logic [bvs_pkg::PACK_W-1:0]    o_cell_mv
);

    logic [bvs_pkg::CELL_W-1:0]  w_c;

    logic                        r_a_valid, n_a_valid;
    logic [bvs_pkg::PACK_W-1:0]  r_a_pack,  n_a_pack;
    logic [bvs_pkg::PROD_W-1:0]  r_a_prod,  n_a_prod;

    logic                        r_b_valid, n_b_valid;
    logic [bvs_pkg::PACK_W-1:0]  r_b_pack,  n_b_pack;
    logic [bvs_pkg::PACK_W-1:0]  r_b_q,     n_b_q;
    logic [bvs_pkg::QC_W-1:0]    r_b_qc,    n_b_qc;

    logic                        r_c_valid, n_c_valid;
    logic [bvs_pkg::PACK_W-1:0]  r_c_v,     n_c_v;

    logic [bvs_pkg::QC_W-1:0]    w_rem;

    assign w_c = (i_cells == '0) ? bvs_pkg::CELL_W'(1) : i_cells;

    // Stage A: pack times reciprocal.
    always_comb begin
        n_a_valid = i_valid;
        n_a_pack  = i_pack;
        n_a_prod  = bvs_pkg::PROD_W'(i_pack) * bvs_pkg::PROD_W'(bvs_pkg::recip(w_c));
    end

    // Stage B: estimate is exact or one short; form estimate times count.
    always_comb begin
        n_b_valid = r_a_valid;
        n_b_pack  = r_a_pack;
        n_b_q     = r_a_prod[bvs_pkg::RECIP_SHIFT +: bvs_pkg::PACK_W];
        n_b_qc    = bvs_pkg::QC_W'(n_b_q) * bvs_pkg::QC_W'(w_c);
    end

    // Stage C: bump the estimate when the remainder still holds a count.
    assign w_rem = bvs_pkg::QC_W'(r_b_pack) - r_b_qc;

    always_comb begin
        n_c_valid = r_b_valid;
        n_c_v     = (w_rem >= bvs_pkg::QC_W'(w_c)) ? r_b_q + 1'b1 : r_b_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_a_valid <= n_a_valid;
            r_b_valid <= n_b_valid;
            r_c_valid <= n_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_pack <= n_a_pack;
        r_a_prod <= n_a_prod;
        r_b_pack <= n_b_pack;
        r_b_q    <= n_b_q;
        r_b_qc   <= n_b_qc;
        r_c_v    <= n_c_v;
    end

    assign o_valid   = r_c_valid;
    assign o_cell_mv = r_c_v;

    `BVS_ASSERT_IMPL(a_est_close, i_clk, i_rst_n, r_b_valid, w_rem < bvs_pkg::QC_W'({w_c, 1'b0}))
    `BVS_ASSERT_NEXT(a_quot_bound, i_clk, i_rst_n, r_b_valid, (bvs_pkg::QC_W'(r_c_v) * bvs_pkg::QC_W'(w_c)) <= bvs_pkg::QC_W'($past(r_b_pack)))

endmodule

// ----- hdl/bvs_seg.sv -----
// Segment search over the breakpoint table and slope product, two stages.
module bvs_seg #(
    parameter int MAX_POINTS = bvs_pkg::MAX_POINTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [bvs_pkg::PACK_W-1:0]    i_v,
    input  bvs_pkg::t_cfg                 i_cfg,
    output logic                          o_valid,
    output bvs_pkg::t_ctl                 o_ctl,
    output logic [bvs_pkg::NUM_W-1:0]     o_num,
    output logic [bvs_pkg::MV_W-1:0]      o_den
);

    localparam int IDX_W = $clog2(MAX_POINTS);

    logic [bvs_pkg::MV_W-1:0]   w_mv  [MAX_POINTS];
    logic [bvs_pkg::SOC_W-1:0]  w_soc [MAX_POINTS];
    logic [MAX_POINTS-2:0]      w_hit;
    logic [bvs_pkg::PCNT_W-1:0] w_n;
    logic [IDX_W-1:0]           w_sel;
    logic [IDX_W-1:0]           w_sel_nx;
    logic [IDX_W-1:0]           w_last;
    bvs_pkg::t_mode             w_mode;

    logic                       r_d_valid, n_d_valid;
    bvs_pkg::t_mode             r_d_mode,  n_d_mode;
    logic [bvs_pkg::SOC_W-1:0]  r_d_s1,    n_d_s1;
    logic [bvs_pkg::MV_W-1:0]   r_d_dv,    n_d_dv;
    logic [bvs_pkg::MV_W-1:0]   r_d_dd,    n_d_dd;
    logic [bvs_pkg::DS_W-1:0]   r_d_ds,    n_d_ds;
    logic [bvs_pkg::PACK_W-1:0] r_d_v,     n_d_v;

    logic                       r_e_valid, n_e_valid;
    bvs_pkg::t_ctl              r_e_ctl,   n_e_ctl;
    logic [bvs_pkg::NUM_W-1:0]  r_e_num,   n_e_num;
    logic [bvs_pkg::MV_W-1:0]   r_e_den,   n_e_den;
    logic [bvs_pkg::SOC_W-1:0]  w_ds_mag;

    // Unpack every breakpoint of the table.
    for (genvar k = 0; k < MAX_POINTS; k++) begin : g_pt
        localparam int WORD = k / 2;
        localparam int LSB  = (k % 2 == 1) ? bvs_pkg::PT_HI_LSB : 0;
        assign w_mv[k]  = i_cfg.tpts[WORD][LSB +: bvs_pkg::MV_W];
        assign w_soc[k] = i_cfg.tpts[WORD][LSB + bvs_pkg::SOC_LSB +: bvs_pkg::SOC_W];
    end

    always_comb begin
        if (i_cfg.point_count < bvs_pkg::PCNT_W'(2)) begin
            w_n = bvs_pkg::PCNT_W'(2);
        end else if (i_cfg.point_count > bvs_pkg::PCNT_W'(MAX_POINTS)) begin
            w_n = bvs_pkg::PCNT_W'(MAX_POINTS);
        end else begin
            w_n = i_cfg.point_count;
        end
    end

    assign w_last = IDX_W'(w_n - 1'b1);

    for (genvar j = 0; j < MAX_POINTS - 1; j++) begin : g_hit
        assign w_hit[j] = (bvs_pkg::PCNT_W'(j + 1) < w_n)
                       && (i_v <= bvs_pkg::PACK_W'(w_mv[j]))
                       && (i_v >= bvs_pkg::PACK_W'(w_mv[j + 1]));
    end

    // First bracketing segment wins.
    always_comb begin
        w_sel = '0;
        for (int i = MAX_POINTS - 2; i >= 0; i--) begin
            if (w_hit[i]) begin
                w_sel = IDX_W'(i);
            end
        end
    end

    assign w_sel_nx = IDX_W'(w_sel + 1'b1);

    always_comb begin
        if (i_v >= bvs_pkg::PACK_W'(w_mv[0])) begin
            w_mode = bvs_pkg::MODE_FULL;
        end else if (i_v <= bvs_pkg::PACK_W'(w_mv[w_last])) begin
            w_mode = bvs_pkg::MODE_EMPTY;
        end else if (|w_hit) begin
            w_mode = bvs_pkg::MODE_INTERP;
        end else begin
            w_mode = bvs_pkg::MODE_EMPTY;
        end
    end

    // Stage D: segment endpoints as distances.
    always_comb begin
        n_d_valid = i_valid;
        n_d_mode  = w_mode;
        n_d_s1    = w_soc[w_sel];
        n_d_dv    = w_mv[w_sel] - i_v[bvs_pkg::MV_W-1:0];
        n_d_dd    = w_mv[w_sel] - w_mv[w_sel_nx];
        n_d_ds    = bvs_pkg::DS_W'(w_soc[w_sel_nx]) - bvs_pkg::DS_W'(w_soc[w_sel]);
        n_d_v     = i_v;
    end

    // Stage E: magnitude product; a flat segment divides zero by one.
    assign w_ds_mag = r_d_ds[bvs_pkg::DS_W-1] ? bvs_pkg::SOC_W'(-r_d_ds)
                                              : r_d_ds[bvs_pkg::SOC_W-1:0];

    always_comb begin
        n_e_valid    = r_d_valid;
        n_e_ctl.mode = r_d_mode;
        n_e_ctl.s1   = r_d_s1;
        n_e_ctl.neg  = r_d_ds[bvs_pkg::DS_W-1];
        n_e_ctl.v    = r_d_v;
        n_e_num      = bvs_pkg::NUM_W'(r_d_dv) * bvs_pkg::NUM_W'(w_ds_mag);
        n_e_den      = (r_d_dd == '0) ? bvs_pkg::MV_W'(1) : r_d_dd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else begin
            r_d_valid <= n_d_valid;
            r_e_valid <= n_e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_mode <= n_d_mode;
        r_d_s1   <= n_d_s1;
        r_d_dv   <= n_d_dv;
        r_d_dd   <= n_d_dd;
        r_d_ds   <= n_d_ds;
        r_d_v    <= n_d_v;
        r_e_ctl  <= n_e_ctl;
        r_e_num  <= n_e_num;
        r_e_den  <= n_e_den;
    end

    assign o_valid = r_e_valid;
    assign o_ctl   = r_e_ctl;
    assign o_num   = r_e_num;
    assign o_den   = r_e_den;

endmodule

// ----- hdl/bvs_qdiv.sv -----
// Pipelined restoring divider, one quotient bit per stage.
`include "battery_voltage_to_soc_top_macros.svh"
module bvs_qdiv (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  bvs_pkg::t_ctl                 i_ctl,
    input  logic [bvs_pkg::NUM_W-1:0]     i_num,
    input  logic [bvs_pkg::MV_W-1:0]      i_den,
    output logic                          o_valid,
    output bvs_pkg::t_ctl                 o_ctl,
    output logic [bvs_pkg::QUO_W-1:0]     o_quo
);

    localparam int LAST = bvs_pkg::QUO_W - 1;

    logic              r_vld [bvs_pkg::QUO_W];
    logic              n_vld [bvs_pkg::QUO_W];
    bvs_pkg::t_qstage  r_st  [bvs_pkg::QUO_W];
    bvs_pkg::t_qstage  n_st  [bvs_pkg::QUO_W];

    for (genvar k = 0; k < bvs_pkg::QUO_W; k++) begin : g_step
        localparam int BIT  = bvs_pkg::QUO_W - 1 - k;
        localparam int PREV = (k == 0) ? 0 : k - 1;

        always_comb begin
            bvs_pkg::t_qstage       prev;
            logic                   prev_v;
            logic [bvs_pkg::NUM_W-1:0] trial;
            if (k == 0) begin
                prev.ctl = i_ctl;
                prev.rem = i_num;
                prev.den = i_den;
                prev.quo = '0;
                prev_v   = i_valid;
            end else begin
                prev   = r_st[PREV];
                prev_v = r_vld[PREV];
            end
            trial    = bvs_pkg::NUM_W'(prev.den) << BIT;
            n_st[k]  = prev;
            n_vld[k] = prev_v;
            if (prev.rem >= trial) begin
                n_st[k].rem      = prev.rem - trial;
                n_st[k].quo[BIT] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= n_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_st[k] <= n_st[k];
        end
    end

    assign o_valid = r_vld[LAST];
    assign o_ctl   = r_st[LAST].ctl;
    assign o_quo   = r_st[LAST].quo;

    `BVS_ASSERT_IMPL(a_rem_below_den, i_clk, i_rst_n, r_vld[LAST] && (r_st[LAST].ctl.mode == bvs_pkg::MODE_INTERP), r_st[LAST].rem < bvs_pkg::NUM_W'(r_st[LAST].den))

endmodule
